[hw/rtl/twmle_pkg.sv]
// Shared types, line patterns and helper functions for the two-wire line encoder.
`timescale 1ns / 1ps

package twmle_pkg;

  // Default depth of the command queue between the front and back parts.
  localparam int unsigned CmdQueueDepth = 2;

  // Number of lead-in states: three neutral states, then the start pattern.
  localparam int unsigned LeadLen  = 13;
  localparam int unsigned EndLen   = 7;
  localparam int unsigned BitCount = 8;

  // One line state, wire A in bit 1 and wire B in bit 0.
  typedef logic [1:0] line_t;

  localparam line_t LineNeutral = 2'b11;

  // Start and end patterns, first state at index 0.
  localparam line_t StartPattern [10] = '{
    2'b01, 2'b00, 2'b01, 2'b00, 2'b01, 2'b00, 2'b01, 2'b00, 2'b01, 2'b11
  };
  localparam line_t EndPattern [7] = '{
    2'b11, 2'b10, 2'b00, 2'b10, 2'b00, 2'b10, 2'b11
  };

  // Input request as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One line state as delivered on the output channel.
  typedef struct packed {
    logic line_a;
    logic line_b;
    logic last_state;
  } out_item_t;

  // Classified request passed from the front part to the back part.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       open_frame;
  } cmd_t;

  // Lead-in state for a step of the lead-in sequence (0 to 12).
  function automatic line_t lead_state(input logic [3:0] step);
    line_t res;
    res = LineNeutral;
    if (step >= 4'd3 && step <= 4'd12) begin
      res = StartPattern[4'(step - 4'd3)];
    end
    return res;
  endfunction

  // End-pattern state for a step of the trailer (0 to 6).
  function automatic line_t end_state(input logic [2:0] step);
    line_t res;
    res = LineNeutral;
    if (step <= 3'd6) begin
      res = EndPattern[step];
    end
    return res;
  endfunction

endpackage

[hw/rtl/twmle_front.sv]
// Front part: accepts byte requests, tracks frame boundaries and queues commands.
`timescale 1ns / 1ps

module twmle_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  twmle_pkg::in_item_t in_item_i,
  output logic               push_o,
  output twmle_pkg::cmd_t    push_cmd_o,
  input  logic               queue_full_i
);

  logic in_frame_q, in_frame_d;
  logic accept;

  // The front only holds off the sender while the queue is full.
  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  // A byte opens a frame when none is open; the last byte closes it.
  always_comb begin
    in_frame_d = in_frame_q;
    if (accept) begin
      in_frame_d = !in_item_i.last_byte;
    end
  end

  assign push_o                = accept;
  assign push_cmd_o.data_byte  = in_item_i.data_byte;
  assign push_cmd_o.last_byte  = in_item_i.last_byte;
  assign push_cmd_o.open_frame = !in_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
    end
  end

endmodule

[hw/rtl/twmle_cmd_queue.sv]
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module twmle_cmd_queue #(
  parameter int unsigned Depth = twmle_pkg::CmdQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  twmle_pkg::cmd_t push_cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output twmle_pkg::cmd_t pop_cmd_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  twmle_pkg::cmd_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = entries_q[rd_ptr_q];

  // Pointer and fill-count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (!do_push && do_pop) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; the fill count guards every read.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[hw/rtl/twmle_back.sv]
// Back part: expands queued commands into line states, one per cycle unless stalled.
`timescale 1ns / 1ps

module twmle_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  output logic                 pop_o,
  input  twmle_pkg::cmd_t      pop_cmd_i,
  input  logic                 queue_empty_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output twmle_pkg::out_item_t out_item_o
);

  typedef enum logic [1:0] {
    PhLead,
    PhData,
    PhEnd
  } phase_e;

  phase_e               phase_q, phase_d;
  logic                 busy_q, busy_d;
  twmle_pkg::cmd_t      cmd_q, cmd_d;
  logic [3:0]           step_q, step_d;
  logic                 prep_done_q, prep_done_d;
  twmle_pkg::line_t     prev_q, prev_d;
  logic                 out_valid_q, out_valid_d;
  twmle_pkg::out_item_t out_item_q, out_item_d;

  logic             emit, finish, start_next;
  twmle_pkg::line_t line;
  logic             line_last;
  logic             bit_val, a_clocks;
  twmle_pkg::line_t clk_state, prep_state;

  // A new state may be produced when the output register is free or being taken.
  assign emit = busy_q && (!out_valid_q || !out_stall_i);

  // Data bit for the current position; even steps are the A-clock positions.
  assign bit_val    = cmd_q.data_byte[3'(3'd7 - step_q[2:0])];
  assign a_clocks   = !step_q[0];
  assign clk_state  = a_clocks ? {1'b0, bit_val} : {bit_val, 1'b0};
  assign prep_state = a_clocks ? {1'b1, bit_val} : {bit_val, 1'b1};

  // Sequencer: lead-in, data bits with optional prepare states, trailer.
  always_comb begin
    phase_d     = phase_q;
    busy_d      = busy_q;
    cmd_d       = cmd_q;
    step_d      = step_q;
    prep_done_d = prep_done_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    finish      = 1'b0;
    line        = prev_q;
    line_last   = 1'b0;

    if (emit) begin
      unique case (phase_q)
        PhLead: begin
          line = twmle_pkg::lead_state(step_q);
          if (step_q == 4'(twmle_pkg::LeadLen - 1)) begin
            phase_d = PhData;
            step_d  = '0;
          end else begin
            step_d = 4'(step_q + 1'b1);
          end
        end
        PhData: begin
          if (!prep_done_q && (prep_state != prev_q)) begin
            line        = prep_state;
            prep_done_d = 1'b1;
          end else begin
            line        = clk_state;
            prep_done_d = 1'b0;
            if (step_q == 4'(twmle_pkg::BitCount - 1)) begin
              step_d = '0;
              if (cmd_q.last_byte) begin
                phase_d = PhEnd;
              end else begin
                line_last = 1'b1;
                finish    = 1'b1;
              end
            end else begin
              step_d = 4'(step_q + 1'b1);
            end
          end
        end
        PhEnd: begin
          line = twmle_pkg::end_state(step_q[2:0]);
          if (step_q == 4'(twmle_pkg::EndLen - 1)) begin
            line_last = 1'b1;
            finish    = 1'b1;
          end else begin
            step_d = 4'(step_q + 1'b1);
          end
        end
        default: begin
          line = prev_q;
        end
      endcase
      out_valid_d           = 1'b1;
      out_item_d.line_a     = line[1];
      out_item_d.line_b     = line[0];
      out_item_d.last_state = line_last;
      prev_d                = line;
    end

    // Take the next command as soon as the current one has produced its last state.
    start_next = (!busy_q || finish) && !queue_empty_i;
    if (start_next) begin
      busy_d      = 1'b1;
      cmd_d       = pop_cmd_i;
      phase_d     = pop_cmd_i.open_frame ? PhLead : PhData;
      step_d      = '0;
      prep_done_d = 1'b0;
    end else if (finish) begin
      busy_d = 1'b0;
    end
  end

  assign pop_o       = start_next;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLead;
      busy_q      <= 1'b0;
      step_q      <= '0;
      prep_done_q <= 1'b0;
      prev_q      <= twmle_pkg::LineNeutral;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      busy_q      <= busy_d;
      step_q      <= step_d;
      prep_done_q <= prep_done_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    out_item_q <= out_item_d;
  end

endmodule

[hw/rtl/two_wire_maple_line_encoder_top.sv]
// Top level of the two-wire line encoder: front part, command queue and back part.
//
// Usage: frame bytes enter on the input channel (in_valid_i, in_stall_o, in_item_i),
// one request per byte, with last_byte set on the byte that ends a frame. Line
// states leave on the output channel (out_valid_o, out_stall_i, out_item_o), one
// item per line state, with last_state set on the final state of each byte's run.
// The first byte of a frame is preceded by three neutral states and the start
// pattern; the last byte is followed by the end pattern.
// Throughput: while out_stall_i is low the back part produces one line state per
// cycle, so a byte yields 8 to 16 states, plus 13 lead-in states when it opens a
// frame and 7 end states as it closes one; the single output register sets that pace.
// An accepted byte passes through the command queue, the back part's command
// register and its output register before its first line state is valid.
// A queue of QueueDepth commands lets further bytes be accepted while the back
// part is busy; in_stall_o is high only while that queue is full.
// When out_stall_i is high a valid state is held and the back part waits behind it.
// Reset empties the queue, closes any open frame and takes neutral as the last level.
`timescale 1ns / 1ps

module two_wire_maple_line_encoder_top #(
  parameter int unsigned QueueDepth = twmle_pkg::CmdQueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  twmle_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output twmle_pkg::out_item_t out_item_o
);

  logic            push, queue_full, pop, queue_empty;
  twmle_pkg::cmd_t push_cmd, pop_cmd;

  twmle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .queue_full_i (queue_full)
  );

  twmle_cmd_queue #(
    .Depth (QueueDepth)
  ) u_cmd_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (queue_full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (queue_empty)
  );

  twmle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_o         (pop),
    .pop_cmd_i     (pop_cmd),
    .queue_empty_i (queue_empty),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

endmodule

[dv/twmle_line_checker.sv]
// Checker for the two-wire line encoder: predicts line states per byte and compares them.
`timescale 1ns / 1ps

module twmle_line_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  twmle_pkg::in_item_t  in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  twmle_pkg::out_item_t out_item_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          states_due_o
);

  // Lead-in (three neutral states, then the start pattern) and the trailer,
  // wire A in bit 1 and wire B in bit 0.
  localparam twmle_pkg::line_t OpenSeq [13] = '{
    2'b11, 2'b11, 2'b11,
    2'b01, 2'b00, 2'b01, 2'b00, 2'b01, 2'b00, 2'b01, 2'b00, 2'b01, 2'b11
  };
  localparam twmle_pkg::line_t CloseSeq [7] = '{
    2'b11, 2'b10, 2'b00, 2'b10, 2'b00, 2'b10, 2'b11
  };

  // Shadow copy of the encoder's frame state.
  logic                 frame_open;
  twmle_pkg::line_t     wire_level;
  twmle_pkg::out_item_t line_states_due [$];

  initial begin
    mismatch_count_o = 0;
    states_due_o     = 0;
    frame_open       = 1'b0;
    wire_level       = 2'b11;
  end

  // Queues one line state and remembers it as the level now on the wires.
  function automatic void queue_line(input twmle_pkg::line_t lvl);
    twmle_pkg::out_item_t st;
    st.line_a     = lvl[1];
    st.line_b     = lvl[0];
    st.last_state = 1'b0;
    line_states_due.push_back(st);
    wire_level = lvl;
  endfunction

  // Works out every line state that one frame byte causes.
  function automatic void encode_byte(input twmle_pkg::in_item_t req);
    twmle_pkg::line_t clk_line;
    twmle_pkg::line_t prep_line;
    if (!frame_open) begin
      foreach (OpenSeq[i]) queue_line(OpenSeq[i]);
      frame_open = 1'b1;
    end
    // Odd bit indices use A as the clock, even ones use B.
    for (int b = 7; b >= 0; b--) begin
      if (b % 2 == 1) begin
        clk_line  = {1'b0, req.data_byte[b]};
        prep_line = {1'b1, req.data_byte[b]};
      end else begin
        clk_line  = {req.data_byte[b], 1'b0};
        prep_line = {req.data_byte[b], 1'b1};
      end
      if (prep_line != wire_level) queue_line(prep_line);
      queue_line(clk_line);
    end
    if (req.last_byte) begin
      foreach (CloseSeq[i]) queue_line(CloseSeq[i]);
      frame_open = 1'b0;
    end
    line_states_due[line_states_due.size() - 1].last_state = 1'b1;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input twmle_pkg::out_item_t got,
                                 input twmle_pkg::out_item_t due);
    $display("[%0t] line state mismatch (%s): got a=%0b b=%0b last=%0b, due a=%0b b=%0b last=%0b",
             $time, what, got.line_a, got.line_b, got.last_state,
             due.line_a, due.line_b, due.last_state);
    mismatch_count_o++;
  endtask

  // Requests are taken at the rising edge; a byte is predicted before the
  // output request of the same edge is compared.
  always @(posedge clk_i or negedge rst_ni) begin
    twmle_pkg::out_item_t due;
    if (!rst_ni) begin
      frame_open = 1'b0;
      wire_level = 2'b11;
      line_states_due.delete();
      states_due_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) encode_byte(in_item_i);
      if (out_valid_i && !out_stall_i) begin
        if (line_states_due.size() == 0) begin
          due = '0;
          report_mismatch("unexpected line state", out_item_i, due);
        end else begin
          due = line_states_due.pop_front();
          if (out_item_i.line_a !== due.line_a)
            report_mismatch("line_a", out_item_i, due);
          if (out_item_i.line_b !== due.line_b)
            report_mismatch("line_b", out_item_i, due);
          if (out_item_i.last_state !== due.last_state)
            report_mismatch("last_state", out_item_i, due);
        end
      end
      states_due_o = line_states_due.size();
    end
  end

endmodule

[dv/tb_two_wire_maple_line_encoder_top.sv]
// Testbench top for the two-wire line encoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_two_wire_maple_line_encoder_top;

  localparam int unsigned RandomBytes = 262;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  twmle_pkg::in_item_t  in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  twmle_pkg::out_item_t out_item;
  logic                 steady_flow = 1'b0;
  int unsigned          mismatches;
  int unsigned          states_due;

  two_wire_maple_line_encoder_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  twmle_line_checker line_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_item_i       (out_item),
    .mismatch_count_o (mismatches),
    .states_due_o     (states_due)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random, except during the steady stretch.
  always @(negedge clk) begin
    out_stall <= !steady_flow && ($urandom_range(0, 99) < 27);
  end

  // Offers one byte, idling at random first, and waits until it is taken.
  task automatic send_byte(input twmle_pkg::in_item_t req);
    while (!steady_flow && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      in_item  <= twmle_pkg::in_item_t'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Directed frames: all-zero and all-one bytes, alternating bit patterns,
  // a skipped prepare state right after the start pattern and across byte
  // boundaries, single-byte and multi-byte frames.
  localparam twmle_pkg::in_item_t DirectedReqs [18] = '{
    '{8'h00, 1'b1}, '{8'hFF, 1'b1}, '{8'h80, 1'b0}, '{8'hAA, 1'b0},
    '{8'h55, 1'b0}, '{8'h01, 1'b0}, '{8'hFE, 1'b0}, '{8'h7F, 1'b1},
    '{8'hAA, 1'b1}, '{8'h55, 1'b0}, '{8'h33, 1'b0}, '{8'hCC, 1'b0},
    '{8'h0F, 1'b0}, '{8'hF0, 1'b1}, '{8'hC3, 1'b0}, '{8'h3C, 1'b0},
    '{8'h5A, 1'b0}, '{8'hA5, 1'b1}
  };

  // Main stimulus and verdict.
  initial begin
    int unsigned         sent;
    int unsigned         frame_len;
    twmle_pkg::in_item_t req;
    sent = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DirectedReqs[i]) send_byte(DirectedReqs[i]);

    // Random frames, mostly short, now and then a long one.
    while (sent < RandomBytes) begin
      if ($urandom_range(0, 7) == 0) frame_len = $urandom_range(7, 12);
      else frame_len = $urandom_range(1, 6);
      for (int k = 0; k < frame_len; k++) begin
        steady_flow     = (sent >= 100 && sent < 160);
        req.data_byte   = 8'($urandom_range(0, 255));
        req.last_byte   = (k == frame_len - 1);
        send_byte(req);
        sent++;
      end
    end
    steady_flow = 1'b0;
    in_valid <= 1'b0;

    // Drain, then give the encoder time to show any stray line states.
    while (states_due != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("two_wire_maple_line_encoder_top verification clean");
    end else begin
      $display("two_wire_maple_line_encoder_top verification failed");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #2_000_000;
    $display("two_wire_maple_line_encoder_top verification failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/twmle_pkg.sv
hw/rtl/twmle_front.sv
hw/rtl/twmle_cmd_queue.sv
hw/rtl/twmle_back.sv
hw/rtl/two_wire_maple_line_encoder_top.sv
dv/twmle_line_checker.sv
dv/tb_two_wire_maple_line_encoder_top.sv
